// ----- rtl/core/wdp_pkg.sv -----
`timescale 1ns / 1ps

package wdp_pkg;

  // Width of the total weight register, which is used as n.
  localparam int TOTAL_WEIGHT_BITS = 28;

  // Configuration register indexes.
  localparam logic CFG_WEIGHT_ENABLE = 1'b0;
  localparam logic CFG_TOTAL_WEIGHT  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_X_FLAT = 2'd1;
  localparam logic [1:0] STATUS_Y_FLAT = 2'd2;

  // Fixed-point limits of the outputs.
  localparam logic [30:0] PEARSON_ONE = 31'h4000_0000;
  localparam logic [31:0] SLOPE_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SLOPE_MIN   = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DRAIN,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_STORE,
    ST_DIFF,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_SQRT_LOAD,
    ST_SQRT_ADD,
    ST_SQRT_CMP,
    ST_FINISH
  } state_t;

  // Products formed by the shared serial multiplier, in the order they are taken.
  typedef enum logic [2:0] {
    PROD_N_SXX,
    PROD_SX_SX,
    PROD_N_SYY,
    PROD_SY_SY,
    PROD_N_SXY,
    PROD_SX_SY,
    PROD_DXX_DYY,
    PROD_NUM_NUM
  } prod_sel_t;

  typedef struct packed {
    logic      mul_load;
    logic      mul_step;
    logic      mul_store;
    logic      diff;
    logic      div_load;
    logic      div_step;
    logic      sqrt_load;
    logic      sqrt_add;
    logic      sqrt_cmp;
    logic      out_load;
    prod_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic x_bad;
    logic y_bad;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/core/wdp_datapath.sv -----
`timescale 1ns / 1ps

module wdp_datapath #(
  parameter int DEGREE_BITS    = 12,
  parameter int WEIGHT_BITS    = 8,
  parameter int MAX_EDGES_LOG2 = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [wdp_pkg::TOTAL_WEIGHT_BITS-1:0] cfg_data,
  input  logic                         in_accept,
  input  logic [DEGREE_BITS-1:0]       x_out_degree,
  input  logic [DEGREE_BITS-1:0]       y_in_degree,
  input  logic [WEIGHT_BITS-1:0]       edge_weight,
  input  wdp_pkg::cmd_t                cmd,
  output wdp_pkg::status_t             sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [63:0]                  out_data,
  output logic [1:0]                   out_user
);

  localparam int NB     = wdp_pkg::TOTAL_WEIGHT_BITS;
  localparam int S1_RAW = DEGREE_BITS + WEIGHT_BITS + MAX_EDGES_LOG2;
  localparam int S2_RAW = 2 * DEGREE_BITS + WEIGHT_BITS + MAX_EDGES_LOG2;
  localparam int S1     = (S1_RAW > 64) ? 64 : S1_RAW;
  localparam int S2     = (S2_RAW > 64) ? 64 : S2_RAW;
  localparam int PA     = NB + S2;
  localparam int PB     = 2 * S1;
  localparam int PRODW  = (PA > PB) ? PA : PB;
  localparam int WX     = WEIGHT_BITS + DEGREE_BITS;
  localparam int WXX    = WEIGHT_BITS + 2 * DEGREE_BITS;
  localparam int DVW    = PRODW + 33;
  localparam int SQW    = 2 * PRODW + 66;
  localparam int CW     = $clog2(PRODW + 1);

  // Configuration.
  logic          weight_enable;
  logic [NB-1:0] total_weight;

  // Accumulation pipeline.
  logic                   s1_valid;
  logic [WX-1:0]          wx;
  logic [WX-1:0]          wy;
  logic [DEGREE_BITS-1:0] x1;
  logic [DEGREE_BITS-1:0] y1;
  logic [WEIGHT_BITS-1:0] w_eff;
  logic [S1-1:0]          sum_x;
  logic [S1-1:0]          sum_y;
  logic [S2-1:0]          sum_xx;
  logic [S2-1:0]          sum_yy;
  logic [S2-1:0]          sum_xy;

  // Serial multiplier and product holding registers.
  logic [PRODW-1:0]   op_a;
  logic [PRODW-1:0]   op_b;
  logic [PRODW-1:0]   mul_a;
  logic [PRODW-1:0]   mul_b;
  logic [2*PRODW-1:0] macc;
  logic [2*PRODW-1:0] pa;
  logic [2*PRODW-1:0] pb;
  logic [CW-1:0]      cnt;

  // Differences and their signs.
  logic             diff_ge;
  logic [PRODW-1:0] diff_mag;
  logic [PRODW-1:0] dxx;
  logic [PRODW-1:0] dyy;
  logic [PRODW-1:0] num;
  logic             nx;
  logic             ny;
  logic             nn;

  // Slope division.
  logic [DVW-1:0] rem;
  logic [DVW-1:0] ds;
  logic [31:0]    quo;

  // Coefficient root search.
  logic signed [SQW-1:0] sq_a;
  logic signed [SQW-1:0] sq_b;
  logic signed [SQW-1:0] sq_p;
  logic signed [SQW-1:0] trial;
  logic signed [SQW-1:0] n2;
  logic [30:0]           qs;

  // Result formatting.
  logic [31:0] slope_val;
  logic [30:0] qs_cap;
  logic [31:0] pearson_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_enable <= 1'b1;
      total_weight  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wdp_pkg::CFG_WEIGHT_ENABLE: weight_enable <= cfg_data[0];
        wdp_pkg::CFG_TOTAL_WEIGHT:  total_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = weight_enable ? edge_weight : WEIGHT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      wx <= WX'(w_eff) * WX'(x_out_degree);
      wy <= WX'(w_eff) * WX'(y_in_degree);
      x1 <= x_out_degree;
      y1 <= y_in_degree;
    end
  end

  // The sums start afresh once a result has been handed to the output register.
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
      sum_xy <= '0;
    end else if (s1_valid) begin
      sum_x  <= sum_x + S1'(wx);
      sum_y  <= sum_y + S1'(wy);
      sum_xx <= sum_xx + S2'(WXX'(wx) * WXX'(x1));
      sum_yy <= sum_yy + S2'(WXX'(wy) * WXX'(y1));
      sum_xy <= sum_xy + S2'(WXX'(wx) * WXX'(y1));
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.sel)
      wdp_pkg::PROD_N_SXX: begin
        op_a = PRODW'(total_weight);
        op_b = PRODW'(sum_xx);
      end
      wdp_pkg::PROD_SX_SX: begin
        op_a = PRODW'(sum_x);
        op_b = PRODW'(sum_x);
      end
      wdp_pkg::PROD_N_SYY: begin
        op_a = PRODW'(total_weight);
        op_b = PRODW'(sum_yy);
      end
      wdp_pkg::PROD_SY_SY: begin
        op_a = PRODW'(sum_y);
        op_b = PRODW'(sum_y);
      end
      wdp_pkg::PROD_N_SXY: begin
        op_a = PRODW'(total_weight);
        op_b = PRODW'(sum_xy);
      end
      wdp_pkg::PROD_SX_SY: begin
        op_a = PRODW'(sum_x);
        op_b = PRODW'(sum_y);
      end
      wdp_pkg::PROD_DXX_DYY: begin
        op_a = dxx;
        op_b = dyy;
      end
      wdp_pkg::PROD_NUM_NUM: begin
        op_a = num;
        op_b = num;
      end
      default: ;
    endcase
  end

  // Shift-and-add multiplier, one bit of the second operand per cycle, MSB first.
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_a <= op_a;
      mul_b <= op_b;
      macc  <= '0;
    end else if (cmd.mul_step) begin
      macc  <= {macc[2*PRODW-2:0], 1'b0} + (mul_b[PRODW-1] ? (2*PRODW)'(mul_a) : '0);
      mul_b <= {mul_b[PRODW-2:0], 1'b0};
    end
  end

  // Even products go to pa and odd ones to pb; in a difference pa is the minuend.
  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      if (cmd.sel[0]) begin
        pb <= macc;
      end else begin
        pa <= macc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.mul_load) begin
      cnt <= CW'(PRODW - 1);
    end else if (cmd.div_load) begin
      cnt <= CW'(31);
    end else if (cmd.sqrt_load) begin
      cnt <= CW'(30);
    end else if (cmd.mul_step || cmd.div_step || cmd.sqrt_cmp) begin
      cnt <= cnt - CW'(1);
    end
  end

  assign diff_ge  = (pa >= pb);
  assign diff_mag = diff_ge ? PRODW'(pa - pb) : PRODW'(pb - pa);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      case (cmd.sel)
        wdp_pkg::PROD_SX_SX: begin
          dxx <= diff_mag;
          nx  <= !diff_ge;
        end
        wdp_pkg::PROD_SY_SY: begin
          dyy <= diff_mag;
          ny  <= !diff_ge;
        end
        wdp_pkg::PROD_SX_SY: begin
          num <= diff_mag;
          nn  <= !diff_ge;
        end
        default: ;
      endcase
    end
  end

  // Restoring division: (|num| * 2^17 + Dxx) / (2 * Dxx), 32 quotient bits.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= (DVW'(num) << 17) + DVW'(dxx);
      ds  <= DVW'(dxx) << 32;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= ds) begin
        rem <= rem - ds;
        quo <= {quo[30:0], 1'b1};
      end else begin
        quo <= {quo[30:0], 1'b0};
      end
      ds <= ds >> 1;
    end
  end

  // Root search for the largest q with (2q-1)^2 * Dxx*Dyy <= num^2 * 2^62.
  // sq_a holds t^2*P for t = 2q-1, sq_b holds t*P and sq_p holds P, each
  // pre-shifted to the weight of the bit being tried, so every step is adds only.
  assign n2 = SQW'(pb) << 62;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sq_a <= SQW'(pa);
      sq_b <= -(SQW'(pa) << 32);
      sq_p <= SQW'(pa) << 62;
      qs   <= '0;
    end else if (cmd.sqrt_add) begin
      trial <= sq_a + sq_b + sq_p;
    end else if (cmd.sqrt_cmp) begin
      if (trial <= n2) begin
        sq_a <= trial;
        sq_b <= (sq_b + (sq_p <<< 1)) >>> 1;
        qs   <= {qs[29:0], 1'b1};
      end else begin
        sq_b <= sq_b >>> 1;
        qs   <= {qs[29:0], 1'b0};
      end
      sq_p <= sq_p >>> 2;
    end
  end

  always_comb begin
    if (quo[31]) begin
      slope_val = nn ? wdp_pkg::SLOPE_MIN : wdp_pkg::SLOPE_MAX;
    end else begin
      slope_val = nn ? (32'd0 - quo) : quo;
    end
    qs_cap      = (qs > wdp_pkg::PEARSON_ONE) ? wdp_pkg::PEARSON_ONE : qs;
    pearson_val = nn ? (32'd0 - {1'b0, qs_cap}) : {1'b0, qs_cap};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.x_bad) begin
        out_data <= '0;
        out_user <= wdp_pkg::STATUS_X_FLAT;
      end else if (sts.y_bad) begin
        out_data <= {slope_val, 32'd0};
        out_user <= wdp_pkg::STATUS_Y_FLAT;
      end else begin
        out_data <= {slope_val, pearson_val};
        out_user <= wdp_pkg::STATUS_OK;
      end
    end
  end

  assign sts.cnt_zero = (cnt == '0);
  assign sts.x_bad    = nx || (dxx == '0);
  assign sts.y_bad    = ny || (dyy == '0);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

// ----- rtl/core/wdp_ctrl.sv -----
`timescale 1ns / 1ps

module wdp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  wdp_pkg::status_t sts,
  output wdp_pkg::cmd_t    cmd
);

  wdp_pkg::state_t    state;
  wdp_pkg::state_t    state_next;
  wdp_pkg::prod_sel_t sel;
  wdp_pkg::prod_sel_t sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wdp_pkg::ST_ACC;
      sel   <= wdp_pkg::PROD_N_SXX;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      wdp_pkg::ST_ACC: begin
        sel_next = wdp_pkg::PROD_N_SXX;
        if (in_valid && in_last) begin
          state_next = wdp_pkg::ST_DRAIN;
        end
      end
      // The drain state lets the final beat reach the sums.
      wdp_pkg::ST_DRAIN:     state_next = wdp_pkg::ST_MUL_LOAD;
      wdp_pkg::ST_MUL_LOAD:  state_next = wdp_pkg::ST_MUL_RUN;
      wdp_pkg::ST_MUL_RUN: begin
        if (sts.cnt_zero) begin
          state_next = wdp_pkg::ST_MUL_STORE;
        end
      end
      wdp_pkg::ST_MUL_STORE: begin
        case (sel)
          wdp_pkg::PROD_SX_SX, wdp_pkg::PROD_SY_SY, wdp_pkg::PROD_SX_SY: begin
            state_next = wdp_pkg::ST_DIFF;
          end
          wdp_pkg::PROD_NUM_NUM: begin
            state_next = wdp_pkg::ST_SQRT_LOAD;
          end
          default: begin
            sel_next   = wdp_pkg::prod_sel_t'(sel + 3'd1);
            state_next = wdp_pkg::ST_MUL_LOAD;
          end
        endcase
      end
      wdp_pkg::ST_DIFF: begin
        if (sel == wdp_pkg::PROD_SX_SY) begin
          state_next = sts.x_bad ? wdp_pkg::ST_FINISH : wdp_pkg::ST_DIV_LOAD;
        end else begin
          sel_next   = wdp_pkg::prod_sel_t'(sel + 3'd1);
          state_next = wdp_pkg::ST_MUL_LOAD;
        end
      end
      wdp_pkg::ST_DIV_LOAD:  state_next = wdp_pkg::ST_DIV_RUN;
      wdp_pkg::ST_DIV_RUN: begin
        if (sts.cnt_zero) begin
          if (sts.y_bad) begin
            state_next = wdp_pkg::ST_FINISH;
          end else begin
            sel_next   = wdp_pkg::PROD_DXX_DYY;
            state_next = wdp_pkg::ST_MUL_LOAD;
          end
        end
      end
      wdp_pkg::ST_SQRT_LOAD: state_next = wdp_pkg::ST_SQRT_ADD;
      wdp_pkg::ST_SQRT_ADD:  state_next = wdp_pkg::ST_SQRT_CMP;
      wdp_pkg::ST_SQRT_CMP: begin
        state_next = sts.cnt_zero ? wdp_pkg::ST_FINISH : wdp_pkg::ST_SQRT_ADD;
      end
      wdp_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          state_next = wdp_pkg::ST_ACC;
        end
      end
      default: state_next = wdp_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel;
    in_ready = 1'b0;
    case (state)
      wdp_pkg::ST_ACC:       in_ready      = 1'b1;
      wdp_pkg::ST_MUL_LOAD:  cmd.mul_load  = 1'b1;
      wdp_pkg::ST_MUL_RUN:   cmd.mul_step  = 1'b1;
      wdp_pkg::ST_MUL_STORE: cmd.mul_store = 1'b1;
      wdp_pkg::ST_DIFF:      cmd.diff      = 1'b1;
      wdp_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
      wdp_pkg::ST_DIV_RUN:   cmd.div_step  = 1'b1;
      wdp_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
      wdp_pkg::ST_SQRT_ADD:  cmd.sqrt_add  = 1'b1;
      wdp_pkg::ST_SQRT_CMP:  cmd.sqrt_cmp  = 1'b1;
      wdp_pkg::ST_FINISH:    cmd.out_load  = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/weighted_directed_pearson.sv -----
`timescale 1ns / 1ps

// Weighted degree correlation of a directed edge stream.
// Each beat on the s_ channel is one edge: source out-degree, target in-degree
// and weight, with s_tlast on the final edge of a data set. Edges are taken one
// per cycle and folded into exact weighted sums through a two-stage pipeline.
// The beat carrying s_tlast starts the evaluation; s_tready stays low until it
// ends. Evaluation runs up to eight products on one shift-and-add multiplier
// (one operand bit per cycle), a 32-step restoring division for the slope and a
// 31-step root search for the coefficient, each step an add and a compare.
// The product width is 80 at the default parameters; evaluation ends early when
// a variance is zero or negative. The single result beat on the m_ channel
// carries the coefficient and slope in m_tdata and the status in m_tuser; the
// sums are cleared as it is loaded into the output register. A stalled receiver
// holds that register and edges are still taken meanwhile; a further result
// waits for it to drain. The user must write configuration through cfg_wr_en,
// cfg_index and cfg_data only while the block is idle; the block does not
// enforce it. Reset clears the sums, enables weighting and sets n to zero.

module weighted_directed_pearson #(
  parameter int DEGREE_BITS    = 12,
  parameter int WEIGHT_BITS    = 8,
  parameter int MAX_EDGES_LOG2 = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [wdp_pkg::TOTAL_WEIGHT_BITS-1:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_out_degree, y_in_degree, edge_weight from the lowest bit up
  input  logic [((2 * DEGREE_BITS + WEIGHT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pearson_corr, slope from the lowest bit up
  output logic [63:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);

  wdp_pkg::cmd_t    cmd;
  wdp_pkg::status_t sts;
  logic             in_accept;

  assign in_accept = s_tvalid && s_tready;

  wdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wdp_datapath #(
    .DEGREE_BITS    (DEGREE_BITS),
    .WEIGHT_BITS    (WEIGHT_BITS),
    .MAX_EDGES_LOG2 (MAX_EDGES_LOG2)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_accept    (in_accept),
    .x_out_degree (s_tdata[DEGREE_BITS-1:0]),
    .y_in_degree  (s_tdata[2*DEGREE_BITS-1:DEGREE_BITS]),
    .edge_weight  (s_tdata[2*DEGREE_BITS+WEIGHT_BITS-1:2*DEGREE_BITS]),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_data     (m_tdata),
    .out_user     (m_tuser)
  );

endmodule

// ----- tb/weighted_directed_pearson_test.sv -----
`timescale 1ns / 1ps

module weighted_directed_pearson_test;

  localparam int LIMIT_CYCLES = 10000000;
  localparam int TARGET_EDGES = 1750;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  w;
    logic        last;
  } edge_item_t;

  typedef struct {
    logic [31:0] pearson;
    logic [31:0] slope;
    logic [1:0]  status;
  } corr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = wdp_pkg::CFG_WEIGHT_ENABLE;
  logic [wdp_pkg::TOTAL_WEIGHT_BITS-1:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // x_out_degree, y_in_degree, edge_weight from the lowest bit up
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // pearson_corr, slope from the lowest bit up
  logic [63:0] m_tdata;
  // status
  logic [1:0]  m_tuser;

  weighted_directed_pearson u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  edge_item_t   edge_q[$];
  corr_result_t corr_q[$];
  edge_item_t   set_q[$];
  int  mismatches = 0;
  int  edges_taken = 0;
  int  edges_planned = 0;
  int  cycles = 0;
  bit  beat_taken = 0;

  // Model copy of the accumulators and registers.
  logic [39:0] acc_x, acc_y;
  logic [51:0] acc_xx, acc_yy, acc_xy;
  logic        wt_on;
  logic [27:0] n_total;

  function automatic int sender_idle();
    if (edges_taken < 600) return 12;
    if (edges_taken < 1200) return 84;
    return 0;
  endfunction

  function automatic int receiver_idle();
    if (edges_taken < 600) return 84;
    if (edges_taken < 1200) return 12;
    return 0;
  endfunction

  function automatic corr_result_t evaluate_sums();
    logic [255:0] n, a, b, dxx, dyy, num, rhs, d2, p, r2;
    logic [63:0]  q, c, t;
    bit nx, ny, nn;
    corr_result_t r;
    r.pearson = '0;
    r.slope = '0;
    r.status = wdp_pkg::STATUS_OK;
    n = 256'(n_total);
    a = n * acc_xx;  b = 256'(acc_x) * acc_x;
    nx = a < b;  dxx = nx ? b - a : a - b;
    a = n * acc_yy;  b = 256'(acc_y) * acc_y;
    ny = a < b;  dyy = ny ? b - a : a - b;
    a = n * acc_xy;  b = 256'(acc_x) * acc_y;
    nn = a < b;  num = nn ? b - a : a - b;
    if (nx || dxx == 0) begin
      r.status = wdp_pkg::STATUS_X_FLAT;
    end else begin
      // Rounded quotient found bit by bit, half away from zero.
      rhs = (num << 17) + dxx;
      d2 = dxx << 1;
      q = 0;
      for (int i = 31; i >= 0; i--) begin
        c = q | (64'd1 << i);
        if (256'(c) * d2 <= rhs) q = c;
      end
      if (!nn) r.slope = (q > 64'h7FFF_FFFF) ? wdp_pkg::SLOPE_MAX : q[31:0];
      else r.slope = (q > 64'h8000_0000) ? wdp_pkg::SLOPE_MIN : 32'(0 - q[31:0]);
      if (ny || dyy == 0) begin
        r.status = wdp_pkg::STATUS_Y_FLAT;
      end else begin
        p = dxx * dyy;
        r2 = (num * num) << 62;
        q = 0;
        for (int i = 30; i >= 0; i--) begin
          c = q | (64'd1 << i);
          t = 2 * c - 1;
          if (256'(t * t) * p <= r2) q = c;
        end
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        r.pearson = nn ? 32'(0 - q[31:0]) : q[31:0];
      end
    end
    return r;
  endfunction

  function automatic void fold_edge(edge_item_t e);
    logic [63:0] w;
    w = wt_on ? 64'(e.w) : 64'd1;
    acc_x  = 40'(acc_x + w * e.x);
    acc_y  = 40'(acc_y + w * e.y);
    acc_xx = 52'(acc_xx + w * e.x * e.x);
    acc_yy = 52'(acc_yy + w * e.y * e.y);
    acc_xy = 52'(acc_xy + w * e.x * e.y);
    if (e.last) begin
      corr_q.push_back(evaluate_sums());
      acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0;
    end
  endfunction

  task automatic write_reg(logic idx, logic [27:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic add_edge(int x, int y, int w);
    edge_item_t e;
    e.x = 12'(x); e.y = 12'(y); e.w = 8'(w); e.last = 1'b0;
    set_q.push_back(e);
  endtask

  // Waits for the block to go quiet, sets the registers, then queues the set.
  task automatic send_set(bit we, bit fixed_n, logic [27:0] n_value);
    logic [27:0] n;
    n = 0;
    foreach (set_q[i]) n += we ? 28'(set_q[i].w) : 28'd1;
    if (fixed_n) n = n_value;
    set_q[set_q.size() - 1].last = 1'b1;
    wait (edge_q.size() == 0 && corr_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(wdp_pkg::CFG_WEIGHT_ENABLE, 28'(we));
    write_reg(wdp_pkg::CFG_TOTAL_WEIGHT, n);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    wt_on = we;
    n_total = n;
    foreach (set_q[i]) begin
      fold_edge(set_q[i]);
      edge_q.push_back(set_q[i]);
    end
    edges_planned += set_q.size();
    set_q.delete();
  endtask

  task automatic random_set();
    int len, kind, xm, cx, cy, x, y, w, r;
    bit we;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 14);
    kind = $urandom_range(5);
    we = ($urandom_range(3) != 0);
    xm = $urandom_range(1) ? 4095 : $urandom_range(1, 63);
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(xm);
      case (kind)
        1: y = (x + $urandom_range(7)) & 4095;
        2: y = 4095 - x;
        3: begin x = cx; y = $urandom_range(xm); end
        4: y = cy;
        default: y = $urandom_range(xm);
      endcase
      case ($urandom_range(7))
        0: w = 0;
        1, 2: w = $urandom_range(255);
        default: w = $urandom_range(1, 4);
      endcase
      add_edge(x, y, w);
    end
    r = $urandom_range(19);
    if (r < 16) send_set(we, 0, 0);
    else if (r == 16) send_set(we, 1, 28'($urandom_range(268435455)));
    else if (r == 17) send_set(we, 1, 28'd0);
    else if (r == 18) send_set(we, 1, 28'hFFF_FFFF);
    else send_set(we, 1, 28'($urandom_range(1, 3)));
  endtask

  // Driver: valid is held until the beat is taken.
  always @(negedge clk) begin
    if (!s_tvalid || beat_taken) begin
      if (edge_q.size() > 0 && $urandom_range(99) >= sender_idle()) begin
        s_tvalid <= 1'b1;
        s_tdata <= {edge_q[0].w, edge_q[0].y, edge_q[0].x};
        s_tlast <= edge_q[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    beat_taken = 0;
    m_tready <= ($urandom_range(99) >= receiver_idle());
  end

  // Monitor and input bookkeeping.
  always @(posedge clk) begin
    cycles++;
    if (s_tvalid && s_tready) begin
      void'(edge_q.pop_front());
      beat_taken = 1;
      edges_taken++;
    end
    if (m_tvalid && m_tready) begin
      if (corr_q.size() == 0) begin
        $error("unexpected result beat: pearson_corr %0h slope %0h status %0d",
               m_tdata[31:0], m_tdata[63:32], m_tuser);
        mismatches++;
      end else begin
        corr_result_t e;
        e = corr_q.pop_front();
        if (m_tdata[31:0] !== e.pearson) begin
          $error("pearson_corr expected %0h actual %0h", e.pearson, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[63:32] !== e.slope) begin
          $error("slope expected %0h actual %0h", e.slope, m_tdata[63:32]);
          mismatches++;
        end
        if (m_tuser !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_tuser);
          mismatches++;
        end
      end
    end
    if (cycles == LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0;
    wt_on = 1'b1;
    n_total = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Single edge at the top of every field: x variance is zero.
    add_edge(4095, 4095, 255);
    send_set(1, 0, 0);
    // Constant target degree: y variance is zero, slope is still given.
    add_edge(1, 7, 3); add_edge(9, 7, 1); add_edge(30, 7, 2);
    send_set(1, 0, 0);
    // Perfect positive and negative relation.
    add_edge(0, 0, 5); add_edge(100, 100, 2); add_edge(4095, 4095, 1);
    send_set(1, 0, 0);
    add_edge(0, 4095, 1); add_edge(2048, 2047, 1); add_edge(4095, 0, 1);
    send_set(1, 0, 0);
    // Weights ignored, with zero weights present.
    add_edge(3, 50, 0); add_edge(40, 2, 170); add_edge(12, 12, 0);
    send_set(0, 0, 0);
    // Total weight of zero makes the x spread negative.
    add_edge(5, 6, 1); add_edge(8, 1, 1);
    send_set(1, 1, 28'd0);
    // Oversized total weight, far above the sum of the edge weights.
    add_edge(4095, 0, 255); add_edge(4094, 4095, 255); add_edge(0, 4095, 1);
    send_set(1, 1, 28'hFFF_FFFF);
    add_edge(1, 4095, 1); add_edge(2, 0, 1);
    send_set(1, 1, 28'd3);

    while (edges_planned < TARGET_EDGES) random_set();

    wait (edge_q.size() == 0 && corr_q.size() == 0);
    repeat (1000) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
